[design/resource_semaphore_wait_signal_defines.svh]
// Assertion macros used by the semaphore unit.
`ifndef RESOURCE_SEMAPHORE_WAIT_SIGNAL_DEFINES_SVH
`define RESOURCE_SEMAPHORE_WAIT_SIGNAL_DEFINES_SVH

// Property must hold at every clock edge outside reset.
`define RSW_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define RSW_ASSERT_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

`endif

[design/rsw_pkg.sv]
package rsw_pkg;

   localparam int NUM_RESOURCES = 8;
   localparam int NUM_PROCESSES = 256;
   localparam int COUNT_WIDTH   = 8;

   localparam int PID_W   = 8;
   localparam int RES_W   = 3;
   localparam int MASK_W  = 8;
   localparam int INIT_W  = 8;
   localparam int FREE_W  = 10;
   localparam int SLOT_W  = 8;
   localparam int LEVEL_W = 9;

   localparam int QUEUE_DEPTH = 256;
   localparam int HELD_DEPTH  = NUM_PROCESSES * NUM_RESOURCES;
   localparam int HELD_AW     = $clog2(HELD_DEPTH);
   localparam int FIFO_DEPTH  = NUM_RESOURCES * QUEUE_DEPTH;
   localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_RESOURCE_MASK     = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_INSTANCES = 1'd1;

   localparam logic OP_WAIT   = 1'b0;
   localparam logic OP_SIGNAL = 1'b1;

   localparam logic signed [FREE_W-1:0] FREE_MIN = {1'b1, {(FREE_W-1){1'b0}}};
   localparam logic signed [FREE_W-1:0] FREE_MAX = {1'b0, {(FREE_W-1){1'b1}}};
   localparam logic [COUNT_WIDTH-1:0]   HELD_MAX = {COUNT_WIDTH{1'b1}};

   typedef enum logic [2:0] {
      ACT_READY_BACK  = 3'd0,
      ACT_READY_FRONT = 3'd1,
      ACT_BLOCKED     = 3'd2,
      ACT_EXIT        = 3'd3,
      ACT_UNBLOCKED   = 3'd4
   } action_type;

   function automatic logic [HELD_AW-1:0] held_addr(input logic [PID_W-1:0] pid,
                                                    input logic [RES_W-1:0] res);
      held_addr = HELD_AW'(pid) * HELD_AW'(NUM_RESOURCES) + HELD_AW'(res);
   endfunction

   function automatic logic [FIFO_AW-1:0] fifo_addr(input logic [RES_W-1:0]  res,
                                                    input logic [SLOT_W-1:0] slot);
      fifo_addr = FIFO_AW'(res) * FIFO_AW'(QUEUE_DEPTH) + FIFO_AW'(slot);
   endfunction

endpackage

[design/rsw_if.sv]
interface rsw_req_if;
   logic                       valid;
   logic                       ready;
   logic                       opcode;
   logic [rsw_pkg::PID_W-1:0]  process_id;
   logic [rsw_pkg::RES_W-1:0]  resource_index;

   modport source (output valid, opcode, process_id, resource_index, input ready);
   modport sink   (input valid, opcode, process_id, resource_index, output ready);
endinterface

interface rsw_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [rsw_pkg::PID_W-1:0]  target_pid;
   rsw_pkg::action_type        action;
   logic                       last_result;

   modport source (output valid, target_pid, action, last_result, input ready);
   modport sink   (input valid, target_pid, action, last_result, output ready);
endinterface

[design/resource_semaphore_wait_signal.sv]
// Counting semaphore unit for up to eight numbered resources. Each request is a
// wait or a signal by one process on one resource and produces one result, or
// two for a signal that wakes a blocked waiter (the signaller first, with
// last_result low, then the waiter). For a plain request the accept cycle
// issues the reads of the held-count memory and the blocked-process queue
// memory, and the execute state decides and writes back once the output queue
// has room. A signal that wakes a waiter goes on through S_WAKE_RD and S_WAKE_WR,
// because the waiter's held count needs a second read-modify-write through the
// single read port of that memory. Results wait in a two-entry output queue, so
// a slow consumer only stalls the block once that queue is full. After reset
// the held-count memory is cleared one entry per cycle, all 2048 entries, during
// which no request is accepted; configuration writes are taken at any time.
// Writing the initial instance register reloads every free count from its byte.
`include "resource_semaphore_wait_signal_defines.svh"

module resource_semaphore_wait_signal (
   input  logic                             clock,
   input  logic                             reset,
   rsw_req_if.sink                          req_chan,
   rsw_rsp_if.source                        rsp_chan,
   input  logic                             csr_wr_en,
   input  logic [rsw_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rsw_pkg::CSR_DATA_W-1:0]   csr_wr_data
);

   typedef enum logic [4:0] {
      S_CLEAR   = 5'b00001,
      S_IDLE    = 5'b00010,
      S_EXEC    = 5'b00100,
      S_WAKE_RD = 5'b01000,
      S_WAKE_WR = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [rsw_pkg::HELD_AW-1:0] clr_ff, clr_in;

   // Request captured at accept, and the waiter id taken when one is woken.
   logic                       op_ff, op_in;
   logic [rsw_pkg::PID_W-1:0]  pid_ff, pid_in;
   logic [rsw_pkg::RES_W-1:0]  res_ff, res_in;
   logic [rsw_pkg::PID_W-1:0]  wake_pid_ff, wake_pid_in;

   // Configuration and per-resource state.
   logic [rsw_pkg::MASK_W-1:0]           mask_ff, mask_in;
   logic signed [rsw_pkg::FREE_W-1:0]    free_ff  [rsw_pkg::NUM_RESOURCES];
   logic signed [rsw_pkg::FREE_W-1:0]    free_in  [rsw_pkg::NUM_RESOURCES];
   logic [rsw_pkg::SLOT_W-1:0]           head_ff  [rsw_pkg::NUM_RESOURCES];
   logic [rsw_pkg::SLOT_W-1:0]           head_in  [rsw_pkg::NUM_RESOURCES];
   logic [rsw_pkg::SLOT_W-1:0]           tail_ff  [rsw_pkg::NUM_RESOURCES];
   logic [rsw_pkg::SLOT_W-1:0]           tail_in  [rsw_pkg::NUM_RESOURCES];
   logic [rsw_pkg::LEVEL_W-1:0]          level_ff [rsw_pkg::NUM_RESOURCES];
   logic [rsw_pkg::LEVEL_W-1:0]          level_in [rsw_pkg::NUM_RESOURCES];

   // Output queue of two results.
   logic [rsw_pkg::PID_W-1:0]  q_pid_ff  [2];
   logic [rsw_pkg::PID_W-1:0]  q_pid_in  [2];
   rsw_pkg::action_type        q_act_ff  [2];
   rsw_pkg::action_type        q_act_in  [2];
   logic                       q_last_ff [2];
   logic                       q_last_in [2];
   logic                       q_rd_ff, q_rd_in;
   logic [1:0]                 q_cnt_ff, q_cnt_in;

   // Memory ports.
   logic                              held_we;
   logic [rsw_pkg::HELD_AW-1:0]       held_wa, held_ra;
   logic [rsw_pkg::COUNT_WIDTH-1:0]   held_wd, held_rd;
   logic                              fifo_we;
   logic [rsw_pkg::FIFO_AW-1:0]       fifo_wa, fifo_ra;
   logic [rsw_pkg::PID_W-1:0]         fifo_rd;

   logic                              accept, pop, can_push, push;
   logic                              wr_slot;
   logic [rsw_pkg::PID_W-1:0]         push_pid;
   rsw_pkg::action_type               push_act;
   logic                              push_last;
   logic                              req_ok;
   logic                              wake_ok;
   logic signed [rsw_pkg::FREE_W-1:0] free_cur, free_dec;
   logic [rsw_pkg::COUNT_WIDTH-1:0]   held_inc;

   rsw_ram #(
      .WIDTH (rsw_pkg::COUNT_WIDTH),
      .DEPTH (rsw_pkg::HELD_DEPTH)
   ) u_held_ram (
      .clock   (clock),
      .wr_en   (held_we),
      .wr_addr (held_wa),
      .wr_data (held_wd),
      .rd_addr (held_ra),
      .rd_data (held_rd)
   );

   rsw_ram #(
      .WIDTH (rsw_pkg::PID_W),
      .DEPTH (rsw_pkg::FIFO_DEPTH)
   ) u_fifo_ram (
      .clock   (clock),
      .wr_en   (fifo_we),
      .wr_addr (fifo_wa),
      .wr_data (pid_ff),
      .rd_addr (fifo_ra),
      .rd_data (fifo_rd)
   );

   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid       = (q_cnt_ff != 2'd0);
   assign rsp_chan.target_pid  = q_pid_ff[q_rd_ff];
   assign rsp_chan.action      = q_act_ff[q_rd_ff];
   assign rsp_chan.last_result = q_last_ff[q_rd_ff];

   assign pop      = rsp_chan.valid && rsp_chan.ready;
   assign can_push = (q_cnt_ff != 2'd2) || pop;
   // With the queue full and popping, the slot freed by the pop is refilled.
   assign wr_slot  = q_rd_ff ^ q_cnt_ff[0];

   // A request is honored only for a defined resource and a known process.
   assign req_ok = ({1'b0, res_ff} < (rsw_pkg::RES_W + 1)'(rsw_pkg::NUM_RESOURCES)) &&
                   mask_ff[res_ff] &&
                   ({1'b0, pid_ff} < (rsw_pkg::PID_W + 1)'(rsw_pkg::NUM_PROCESSES));
   assign wake_ok = ({1'b0, wake_pid_ff} <
                     (rsw_pkg::PID_W + 1)'(rsw_pkg::NUM_PROCESSES));

   assign free_cur = free_ff[res_ff];
   assign free_dec = (free_cur == rsw_pkg::FREE_MIN) ? rsw_pkg::FREE_MIN
                                                      : free_cur - rsw_pkg::FREE_W'(1);
   assign held_inc = (held_rd == rsw_pkg::HELD_MAX) ? held_rd
                                                     : held_rd + 1'b1;

   // Read addresses: at accept the reads come straight from the request, later
   // from the captured request so a stalled execute cycle sees the same data.
   always_comb begin
      if (state_ff == S_IDLE) begin
         held_ra = rsw_pkg::held_addr(req_chan.process_id, req_chan.resource_index);
         fifo_ra = rsw_pkg::fifo_addr(req_chan.resource_index,
                                      head_ff[req_chan.resource_index]);
      end else if (state_ff == S_WAKE_RD) begin
         held_ra = rsw_pkg::held_addr(wake_pid_ff, res_ff);
         fifo_ra = rsw_pkg::fifo_addr(res_ff, head_ff[res_ff]);
      end else begin
         held_ra = rsw_pkg::held_addr(pid_ff, res_ff);
         fifo_ra = rsw_pkg::fifo_addr(res_ff, head_ff[res_ff]);
      end
   end

   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      op_in       = op_ff;
      pid_in      = pid_ff;
      res_in      = res_ff;
      wake_pid_in = wake_pid_ff;
      mask_in     = mask_ff;
      free_in     = free_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      level_in    = level_ff;

      held_we   = 1'b0;
      held_wa   = rsw_pkg::held_addr(pid_ff, res_ff);
      held_wd   = '0;
      fifo_we   = 1'b0;
      fifo_wa   = rsw_pkg::fifo_addr(res_ff, tail_ff[res_ff]);
      push      = 1'b0;
      push_pid  = pid_ff;
      push_act  = rsw_pkg::ACT_EXIT;
      push_last = 1'b1;

      unique case (state_ff)
         S_CLEAR: begin
            held_we = 1'b1;
            held_wa = clr_ff;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == rsw_pkg::HELD_AW'(rsw_pkg::HELD_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               op_in    = req_chan.opcode;
               pid_in   = req_chan.process_id;
               res_in   = req_chan.resource_index;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (can_push) begin
               push     = 1'b1;
               state_in = S_IDLE;
               if (!req_ok) begin
                  push_act = rsw_pkg::ACT_EXIT;
               end else if (op_ff == rsw_pkg::OP_WAIT) begin
                  if (!free_dec[rsw_pkg::FREE_W-1]) begin
                     free_in[res_ff] = free_dec;
                     held_we  = 1'b1;
                     held_wd  = held_inc;
                     push_act = rsw_pkg::ACT_READY_BACK;
                  end else if (level_ff[res_ff] ==
                               rsw_pkg::LEVEL_W'(rsw_pkg::QUEUE_DEPTH)) begin
                     push_act = rsw_pkg::ACT_EXIT;
                  end else begin
                     free_in[res_ff]  = free_dec;
                     fifo_we          = 1'b1;
                     tail_in[res_ff]  = tail_ff[res_ff] + 1'b1;
                     level_in[res_ff] = level_ff[res_ff] + 1'b1;
                     push_act         = rsw_pkg::ACT_BLOCKED;
                  end
               end else begin
                  if (held_rd == '0) begin
                     push_act = rsw_pkg::ACT_EXIT;
                  end else begin
                     if (free_cur != rsw_pkg::FREE_MAX) begin
                        free_in[res_ff] = free_cur + rsw_pkg::FREE_W'(1);
                     end
                     held_we  = 1'b1;
                     held_wd  = held_rd - 1'b1;
                     push_act = rsw_pkg::ACT_READY_FRONT;
                     if (level_ff[res_ff] != '0) begin
                        // Oldest waiter leaves the queue; its credit follows.
                        wake_pid_in      = fifo_rd;
                        head_in[res_ff]  = head_ff[res_ff] + 1'b1;
                        level_in[res_ff] = level_ff[res_ff] - 1'b1;
                        push_last        = 1'b0;
                        state_in         = S_WAKE_RD;
                     end
                  end
               end
            end
         end
         S_WAKE_RD: begin
            if (can_push) begin
               push      = 1'b1;
               push_pid  = wake_pid_ff;
               push_act  = rsw_pkg::ACT_UNBLOCKED;
               push_last = 1'b1;
               state_in  = S_WAKE_WR;
            end
         end
         S_WAKE_WR: begin
            held_we  = wake_ok;
            held_wa  = rsw_pkg::held_addr(wake_pid_ff, res_ff);
            held_wd  = held_inc;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_wr_en) begin
         unique case (csr_index)
            rsw_pkg::CSR_RESOURCE_MASK: begin
               mask_in = csr_wr_data[rsw_pkg::MASK_W-1:0];
            end
            rsw_pkg::CSR_INITIAL_INSTANCES: begin
               for (int i = 0; i < rsw_pkg::NUM_RESOURCES; i++) begin
                  free_in[i] = rsw_pkg::FREE_W'(csr_wr_data[rsw_pkg::INIT_W*i +:
                                                            rsw_pkg::INIT_W]);
               end
            end
            default: begin
               mask_in = mask_ff;
            end
         endcase
      end
   end

   always_comb begin
      q_pid_in  = q_pid_ff;
      q_act_in  = q_act_ff;
      q_last_in = q_last_ff;
      if (push) begin
         q_pid_in[wr_slot]  = push_pid;
         q_act_in[wr_slot]  = push_act;
         q_last_in[wr_slot] = push_last;
      end
      q_rd_in  = q_rd_ff ^ pop;
      q_cnt_in = q_cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         res_ff   <= '0;
         mask_ff  <= '0;
         q_rd_ff  <= 1'b0;
         q_cnt_ff <= 2'd0;
         for (int i = 0; i < rsw_pkg::NUM_RESOURCES; i++) begin
            free_ff[i]  <= '0;
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            level_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         res_ff   <= res_in;
         mask_ff  <= mask_in;
         q_rd_ff  <= q_rd_in;
         q_cnt_ff <= q_cnt_in;
         free_ff  <= free_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      pid_ff      <= pid_in;
      wake_pid_ff <= wake_pid_in;
      q_pid_ff    <= q_pid_in;
      q_act_ff    <= q_act_in;
      q_last_ff   <= q_last_in;
   end

   `RSW_ASSERT_NEVER(a_queue_overflow, q_cnt_ff == 2'd3, "output queue holds more than two results")
   `RSW_ASSERT(a_level_bound, level_ff[res_ff] <= rsw_pkg::LEVEL_W'(rsw_pkg::QUEUE_DEPTH), "blocked queue level beyond depth")
   `RSW_ASSERT(a_ptr_level, tail_ff[res_ff] == rsw_pkg::SLOT_W'(head_ff[res_ff] + level_ff[res_ff]), "queue pointers disagree with level")
   `RSW_ASSERT(a_wake_order, (state_ff == S_WAKE_WR) |-> ($past(state_ff) == S_WAKE_RD), "waiter credit written without its read")

endmodule

[design/rsw_ram.sv]
module rsw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
